>>> rtl/icg_pkg.sv
package icg_pkg;

    // Default word width of the generator registers.
    localparam int ICG_WORD_BITS = 16;

    // Value the modulus register takes at reset, before truncation to the word width.
    localparam int ICG_RESET_MODULUS = 65521;

    // Byte address width of the register port: five 32-bit registers.
    localparam int ICG_ADDR_BITS = 5;
    localparam int ICG_DATA_BITS = 32;

    typedef logic [2:0] icg_reg_idx_t;

    localparam icg_reg_idx_t ICG_REG_MODULUS    = 3'd0;
    localparam icg_reg_idx_t ICG_REG_MULTIPLIER = 3'd1;
    localparam icg_reg_idx_t ICG_REG_ADDEND     = 3'd2;
    localparam icg_reg_idx_t ICG_REG_MIN_VALUE  = 3'd3;
    localparam icg_reg_idx_t ICG_REG_START_SEED = 3'd4;

endpackage

>>> rtl/inversive_congruential_prng_core.sv
// Inversive congruential pseudo-random number generator.
//
// Request channel (req_valid, req_stall, restart): each transaction draws one
// number. With restart set, the seed is first reloaded from start_seed.
// Response channel (rsp_valid, rsp_stall, random_value): one transaction per
// request, in request order. The result sits in an output register, so a new
// request is taken while an earlier result still waits for the receiver.
// Registers are written and read over the APB port at byte address 4*index.
//
// A draw runs on one shared restoring divider that retires one quotient bit
// per cycle, and on the extended Euclid loop that runs on it. A zero seed skips
// the seed reduction and the Euclid loop and only maps the addend; a seed whose
// residue is zero skips the Euclid loop. req_stall is high while a draw is in
// progress and while the finished result waits for a stalled receiver to free
// the output register.
// Reset clears the seed to zero and loads the register defaults.
module inversive_congruential_prng_core
    import icg_pkg::*;
#(
    parameter int WORD_BITS = ICG_WORD_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ICG_ADDR_BITS-1:0] paddr,
    input  logic [ICG_DATA_BITS-1:0] pwdata,
    output logic [ICG_DATA_BITS-1:0] prdata,
    output logic                     pready,

    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     restart,

    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [WORD_BITS-1:0]     random_value
);

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * W + 1;
    localparam int CW = $clog2(DW + 1);

    localparam logic [W-1:0] MOD_TRUNC = W'(ICG_RESET_MODULUS);
    localparam logic [W-1:0] RST_MOD   = (MOD_TRUNC < W'(2)) ? W'(2) : MOD_TRUNC;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SMOD  = 4'd1;
    localparam logic [3:0] S_EDIV  = 4'd2;
    localparam logic [3:0] S_EMUL  = 4'd3;
    localparam logic [3:0] S_EUPD  = 4'd4;
    localparam logic [3:0] S_EFIN  = 4'd5;
    localparam logic [3:0] S_AMUL  = 4'd6;
    localparam logic [3:0] S_RLOAD = 4'd7;
    localparam logic [3:0] S_RMOD  = 4'd8;
    localparam logic [3:0] S_MMOD  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // Control and configuration state
    logic [3:0]   state_reg, state_next;
    logic         rsp_valid_reg, rsp_valid_next;
    logic [W-1:0] modulus_reg, modulus_next;
    logic [W-1:0] multiplier_reg, multiplier_next;
    logic [W-1:0] addend_reg, addend_next;
    logic [W-1:0] min_value_reg, min_value_next;
    logic [W-1:0] start_seed_reg, start_seed_next;
    logic [W-1:0] seed_reg, seed_next;

    // Datapath
    logic [W-1:0]          div_rem_reg, div_rem_next;
    logic [DW-1:0]         div_shf_reg, div_shf_next;
    logic [W:0]            div_dsr_reg, div_dsr_next;
    logic [CW-1:0]         div_cnt_reg, div_cnt_next;
    logic [W-1:0]          r0_reg, r0_next;
    logic [W-1:0]          r1_reg, r1_next;
    logic signed [W+1:0]   t0_reg, t0_next;
    logic signed [W+1:0]   t1_reg, t1_next;
    logic [W-1:0]          q_reg, q_next;
    logic signed [2*W+2:0] prod_reg, prod_next;
    logic [W-1:0]          inv_reg, inv_next;
    logic [W-1:0]          res_reg, res_next;
    logic [W-1:0]          rsp_data_reg, rsp_data_next;

    logic                  cfg_wr;
    icg_reg_idx_t          cfg_idx;
    logic [W-1:0]          wval;
    logic [W-1:0]          mod_new;
    logic [W-1:0]          lo;
    logic [W:0]            map_dsr;
    logic [W:0]            div_partial;
    logic [W:0]            div_diff;
    logic                  div_ge;
    logic                  div_busy;
    logic signed [W:0]     mul_x;
    logic signed [W+1:0]   mul_y;
    logic signed [2*W+2:0] mul_p;
    logic [DW-1:0]         sum_ab;
    logic signed [W+1:0]   t_new;
    logic signed [W+1:0]   t_fix;
    logic [W-1:0]          seed_sel;
    logic                  req_take;
    logic                  out_free;

    assign pready    = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign random_value = rsp_data_reg;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ICG_ADDR_BITS-1:2];
    assign wval    = pwdata[W-1:0];
    assign mod_new = (wval < W'(2)) ? W'(2) : wval;

    always_comb
    begin
        unique case (cfg_idx)
            ICG_REG_MODULUS:    prdata = ICG_DATA_BITS'(modulus_reg);
            ICG_REG_MULTIPLIER: prdata = ICG_DATA_BITS'(multiplier_reg);
            ICG_REG_ADDEND:     prdata = ICG_DATA_BITS'(addend_reg);
            ICG_REG_MIN_VALUE:  prdata = ICG_DATA_BITS'(min_value_reg);
            ICG_REG_START_SEED: prdata = ICG_DATA_BITS'(start_seed_reg);
            default:            prdata = '0;
        endcase
    end

    assign lo      = (min_value_reg > modulus_reg) ? modulus_reg : min_value_reg;
    assign map_dsr = {1'b0, modulus_reg} - {1'b0, lo} + (W+1)'(1);

    // One restoring division step: bring in the next dividend bit, subtract if it fits.
    assign div_partial = {div_rem_reg, div_shf_reg[DW-1]};
    assign div_ge      = (div_partial >= div_dsr_reg);
    assign div_diff    = div_partial - div_dsr_reg;
    assign div_busy    = (div_cnt_reg != '0);

    // Shared multiplier: quotient times coefficient in Euclid, a times inverse after it.
    assign mul_x = (state_reg == S_AMUL) ? $signed({1'b0, multiplier_reg})
                                         : $signed({1'b0, q_reg});
    assign mul_y = (state_reg == S_AMUL) ? $signed({2'b00, inv_reg}) : t1_reg;
    assign mul_p = mul_x * mul_y;

    assign sum_ab = DW'(prod_reg[2*W-1:0]) + DW'(addend_reg);
    assign t_new  = t0_reg - prod_reg[W+1:0];
    assign t_fix  = t0_reg + $signed({2'b00, modulus_reg});

    assign seed_sel = restart ? start_seed_reg : seed_reg;
    assign req_take = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        modulus_next    = modulus_reg;
        multiplier_next = multiplier_reg;
        addend_next     = addend_reg;
        min_value_next  = min_value_reg;
        start_seed_next = start_seed_reg;
        seed_next       = seed_reg;
        div_rem_next    = div_rem_reg;
        div_shf_next    = div_shf_reg;
        div_dsr_next    = div_dsr_reg;
        div_cnt_next    = div_cnt_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        q_next          = q_reg;
        prod_next       = prod_reg;
        inv_next        = inv_reg;
        res_next        = res_reg;
        rsp_data_next   = rsp_data_reg;

        if (cfg_wr) begin
            unique case (cfg_idx)
                ICG_REG_MODULUS:
                begin
                    modulus_next = mod_new;
                    if (multiplier_reg > mod_new) begin
                        multiplier_next = W'(1);
                    end
                    if (addend_reg > mod_new) begin
                        addend_next = W'(1);
                    end
                end
                ICG_REG_MULTIPLIER:
                begin
                    multiplier_next = (wval == '0 || wval > modulus_reg) ? W'(1) : wval;
                end
                ICG_REG_ADDEND:
                begin
                    addend_next = (wval == '0 || wval > modulus_reg) ? W'(1) : wval;
                end
                ICG_REG_MIN_VALUE:  min_value_next = wval;
                ICG_REG_START_SEED: start_seed_next = wval;
                default:
                begin
                end
            endcase
        end

        if (rsp_valid_reg && !rsp_stall) begin
            rsp_valid_next = 1'b0;
        end

        if (div_busy) begin
            div_rem_next = div_ge ? div_diff[W-1:0] : div_partial[W-1:0];
            div_shf_next = {div_shf_reg[DW-2:0], div_ge};
            div_cnt_next = div_cnt_reg - CW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take) begin
                    seed_next    = seed_sel;
                    div_rem_next = '0;
                    div_cnt_next = CW'(W);
                    if (seed_sel == '0) begin
                        // A zero seed skips the generator and maps the addend directly.
                        div_shf_next = {addend_reg, {(W+1){1'b0}}};
                        div_dsr_next = map_dsr;
                        state_next   = S_MMOD;
                    end else begin
                        div_shf_next = {seed_sel, {(W+1){1'b0}}};
                        div_dsr_next = {1'b0, modulus_reg};
                        state_next   = S_SMOD;
                    end
                end
            end
            S_SMOD:
            begin
                if (!div_busy) begin
                    if (div_rem_reg == '0) begin
                        inv_next   = '0;
                        state_next = S_AMUL;
                    end else begin
                        r0_next      = modulus_reg;
                        r1_next      = div_rem_reg;
                        t0_next      = '0;
                        t1_next      = (W+2)'(1);
                        div_rem_next = '0;
                        div_shf_next = {modulus_reg, {(W+1){1'b0}}};
                        div_dsr_next = {1'b0, div_rem_reg};
                        div_cnt_next = CW'(W);
                        state_next   = S_EDIV;
                    end
                end
            end
            S_EDIV:
            begin
                if (!div_busy) begin
                    q_next     = div_shf_reg[W-1:0];
                    r0_next    = r1_reg;
                    r1_next    = div_rem_reg;
                    state_next = S_EMUL;
                end
            end
            S_EMUL:
            begin
                prod_next  = mul_p;
                state_next = S_EUPD;
            end
            S_EUPD:
            begin
                t0_next = t1_reg;
                t1_next = t_new;
                if (r1_reg != '0) begin
                    div_rem_next = '0;
                    div_shf_next = {r0_reg, {(W+1){1'b0}}};
                    div_dsr_next = {1'b0, r1_reg};
                    div_cnt_next = CW'(W);
                    state_next   = S_EDIV;
                end else begin
                    state_next = S_EFIN;
                end
            end
            S_EFIN:
            begin
                // A final remainder other than one means the seed shares a factor with p.
                if (r0_reg != W'(1)) begin
                    inv_next = '0;
                end else if (t0_reg[W+1]) begin
                    inv_next = t_fix[W-1:0];
                end else begin
                    inv_next = t0_reg[W-1:0];
                end
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                prod_next  = mul_p;
                state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                div_rem_next = '0;
                div_shf_next = sum_ab;
                div_dsr_next = {1'b0, modulus_reg};
                div_cnt_next = CW'(DW);
                state_next   = S_RMOD;
            end
            S_RMOD:
            begin
                if (!div_busy) begin
                    div_shf_next = {div_rem_reg, {(W+1){1'b0}}};
                    div_rem_next = '0;
                    div_dsr_next = map_dsr;
                    div_cnt_next = CW'(W);
                    state_next   = S_MMOD;
                end
            end
            S_MMOD:
            begin
                if (!div_busy) begin
                    res_next   = lo + div_rem_reg;
                    seed_next  = lo + div_rem_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free) begin
                    rsp_data_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            modulus_reg    <= RST_MOD;
            multiplier_reg <= W'(1);
            addend_reg     <= W'(1);
            min_value_reg  <= '0;
            start_seed_reg <= '0;
            seed_reg       <= '0;
            div_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            modulus_reg    <= modulus_next;
            multiplier_reg <= multiplier_next;
            addend_reg     <= addend_next;
            min_value_reg  <= min_value_next;
            start_seed_reg <= start_seed_next;
            seed_reg       <= seed_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg  <= div_rem_next;
        div_shf_reg  <= div_shf_next;
        div_dsr_reg  <= div_dsr_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        q_reg        <= q_next;
        prod_reg     <= prod_next;
        inv_reg      <= inv_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

`ifndef ASSERT_OFF
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SMOD || state_reg == S_EDIV || state_reg == S_RMOD ||
         state_reg == S_MMOD) |-> (div_rem_reg < W'(div_dsr_reg) || div_dsr_reg[W]))
        else $error("divider remainder not below divisor");

    a_euclid_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EUPD) |-> (r1_reg < r0_reg))
        else $error("Euclid remainder did not shrink");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_SMOD || state_reg == S_MMOD))
        else $error("accepted request did not start a draw");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("response raised outside the output state");
`endif

endmodule

>>> test/tb_inversive_congruential_prng_core.sv
module tb_inversive_congruential_prng_core
    import icg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT  = 4000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 104;
    localparam int TAIL_CYCLES  = 4 * ICG_WORD_BITS + 20;

    class icg_draw_predictor;
        typedef logic [ICG_WORD_BITS-1:0] word_t;

        word_t modulus;
        word_t multiplier;
        word_t addend;
        word_t min_value;
        word_t start_seed;
        word_t seed;
        word_t upcoming_values[$];
        int    mismatches;

        function new();
            modulus    = word_t'(ICG_RESET_MODULUS);
            multiplier = 1;
            addend     = 1;
            min_value  = 0;
            start_seed = 0;
            seed       = 0;
            mismatches = 0;
        endfunction

        // Extended Euclid; zero when r and p share a factor.
        function longint unsigned inverse_mod(longint unsigned r, longint unsigned p);
            longint prev_r;
            longint cur_r;
            longint prev_t;
            longint cur_t;
            longint q;
            longint tmp;
            prev_r = longint'(p);
            cur_r  = longint'(r);
            prev_t = 0;
            cur_t  = 1;
            while (cur_r != 0)
            begin
                q      = prev_r / cur_r;
                tmp    = prev_r - q * cur_r;
                prev_r = cur_r;
                cur_r  = tmp;
                tmp    = prev_t - q * cur_t;
                prev_t = cur_t;
                cur_t  = tmp;
            end
            if (prev_r != 1)
                return 0;
            if (prev_t < 0)
                prev_t += longint'(p);
            return longint'(prev_t);
        endfunction

        function void apply_write(icg_reg_idx_t idx, logic [ICG_DATA_BITS-1:0] data);
            word_t v;
            v = data[ICG_WORD_BITS-1:0];
            case (idx)
                ICG_REG_MODULUS:
                begin
                    modulus = (v < 2) ? word_t'(2) : v;
                    if (multiplier > modulus)
                        multiplier = 1;
                    if (addend > modulus)
                        addend = 1;
                end
                ICG_REG_MULTIPLIER: multiplier = (v == 0 || v > modulus) ? word_t'(1) : v;
                ICG_REG_ADDEND:     addend = (v == 0 || v > modulus) ? word_t'(1) : v;
                ICG_REG_MIN_VALUE:  min_value = v;
                ICG_REG_START_SEED: start_seed = v;
                default: ;
            endcase
        endfunction

        function void note_request(bit reload);
            longint unsigned p;
            longint unsigned lo;
            longint unsigned raw;
            longint unsigned r;
            longint unsigned inv;
            p  = modulus;
            lo = (min_value > modulus) ? modulus : min_value;
            if (reload)
                seed = start_seed;
            if (seed == 0)
                raw = addend;
            else
            begin
                r   = seed % p;
                inv = (r == 0) ? 0 : inverse_mod(r, p);
                raw = (multiplier * inv + addend) % p;
            end
            seed = word_t'(lo + raw % (p - lo + 1));
            upcoming_values.push_back(seed);
        endfunction

        function void check_value(word_t got);
            word_t want;
            if (upcoming_values.size() == 0)
            begin
                mismatches++;
                $error("random_value: no transaction expected, actual %0d", got);
                return;
            end
            want = upcoming_values.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $error("random_value: expected %0d, actual %0d", want, got);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ICG_ADDR_BITS-1:0] paddr;
    logic [ICG_DATA_BITS-1:0] pwdata;
    logic [ICG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     req_valid;
    logic                     req_stall;
    logic                     restart;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [ICG_WORD_BITS-1:0] random_value;

    icg_draw_predictor predictor;
    bit                send_idle;
    bit                recv_idle;
    int                stuck_cycles = 0;

    inversive_congruential_prng_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .restart      (restart),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .random_value (random_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Lowers the request valid and waits until every draw has been returned.
    task automatic drain();
        req_valid <= 1'b0;
        while (predictor.upcoming_values.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(icg_reg_idx_t idx, logic [ICG_DATA_BITS-1:0] data);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ICG_ADDR_BITS'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        predictor.apply_write(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(input bit reload);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        restart   <= reload;
        do @(posedge clk); while (req_stall);
        predictor.note_request(reload);
        @(negedge clk);
    endtask

    function automatic logic [ICG_DATA_BITS-1:0] pick_coefficient();
        if ($urandom_range(0, 5) == 0)
            return $urandom();
        return $urandom_range(1, predictor.modulus);
    endfunction

    // Response side: a stall, when drawn, starts before the result and is released
    // a randomly drawn time after it shows up.
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = recv_idle ? $urandom_range(0, 9) : 0;
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                do @(posedge clk); while (!rsp_valid);
                repeat (hold - 1) @(posedge clk);
                @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
            predictor.check_value(random_value);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        int                       pause_at;
        bit                       modulus_last;
        logic [ICG_DATA_BITS-1:0] mod_word;
        logic [ICG_DATA_BITS-1:0] min_word;

        predictor = new();
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        restart   = 1'b0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a zero seed yields the addend, then the chain runs.
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // A modulus below two is raised to two.
        apb_write(ICG_REG_MODULUS, 0);
        send_request(1'b0);
        send_request(1'b1);
        apb_write(ICG_REG_MODULUS, 1);
        send_request(1'b0);

        // Everything at the top of the word; the seed's residue is zero.
        apb_write(ICG_REG_MODULUS, 32'hFFFF_FFFF);
        apb_write(ICG_REG_MULTIPLIER, 32'h0000_FFFF);
        apb_write(ICG_REG_ADDEND, 32'h0000_FFFF);
        apb_write(ICG_REG_MIN_VALUE, 32'h0000_FFFF);
        apb_write(ICG_REG_START_SEED, 32'hFFFF_FFFF);
        send_request(1'b1);
        send_request(1'b0);

        // Shrinking the modulus resets multiplier and addend; the minimum
        // above the modulus pins the output at the modulus.
        apb_write(ICG_REG_MODULUS, 101);
        apb_write(ICG_REG_MIN_VALUE, 200);
        send_request(1'b0);
        send_request(1'b1);

        // A seed that shares a factor with the modulus has no inverse.
        apb_write(ICG_REG_MODULUS, 100);
        apb_write(ICG_REG_MIN_VALUE, 0);
        apb_write(ICG_REG_START_SEED, 10);
        apb_write(ICG_REG_MULTIPLIER, 37);
        apb_write(ICG_REG_ADDEND, 100);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // Coefficients are checked against the modulus held at write time.
        apb_write(ICG_REG_MULTIPLIER, 0);
        apb_write(ICG_REG_ADDEND, 101);
        apb_write(ICG_REG_MODULUS, 65521);
        apb_write(ICG_REG_MULTIPLIER, 65521);
        apb_write(ICG_REG_ADDEND, 65522);

        // A new start seed only takes effect on restart.
        apb_write(ICG_REG_START_SEED, 12345);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        for (int k = int'(ICG_REG_START_SEED) + 1; k < (1 << $bits(icg_reg_idx_t)); k++)
            apb_write(icg_reg_idx_t'(k), $urandom());
        send_request(1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0: mod_word = 65521;
                1: mod_word = $urandom_range(2, 31);
                2: mod_word = $urandom();
                default: mod_word = $urandom_range(0, 1) ? 32'd2 : 32'h0000_FFFF;
            endcase
            modulus_last = $urandom_range(0, 2) == 0;
            if (!modulus_last)
                apb_write(ICG_REG_MODULUS, mod_word);
            apb_write(ICG_REG_MULTIPLIER, pick_coefficient());
            apb_write(ICG_REG_ADDEND, pick_coefficient());
            case ($urandom_range(0, 3))
                0, 1: min_word = 0;
                2: min_word = $urandom_range(0, predictor.modulus);
                default: min_word = $urandom();
            endcase
            apb_write(ICG_REG_MIN_VALUE, min_word);
            apb_write(ICG_REG_START_SEED, $urandom());
            if (modulus_last)
                apb_write(ICG_REG_MODULUS, mod_word);
            if ($urandom_range(0, 3) == 0)
                apb_write(icg_reg_idx_t'($urandom_range(int'(ICG_REG_START_SEED) + 1,
                                                        (1 << $bits(icg_reg_idx_t)) - 1)),
                          $urandom());

            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            pause_at  = $urandom_range(0, PHASE_ITEMS - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold off once per phase until the block has caught up.
                if (i == pause_at)
                    drain();
                send_request($urandom_range(0, 7) == 0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predictor.mismatches == 0 && predictor.upcoming_values.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
